/* hdl/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the per-source flood detector.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int TABLE_ENTRIES  = 256;
    localparam int IDX_W          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W          = $clog2(TABLE_ENTRIES + 1);
    localparam int SWEEP_INTERVAL = 30;
    localparam int THR_W          = 20;
    localparam int WIN_W          = 16;
    localparam int LIMIT_W        = THR_W + 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [1:0] CFG_RATE_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WINDOW         = 2'd1;
    localparam logic [1:0] CFG_MAX_CONN       = 2'd2;

    localparam logic OPC_ANALYZE = 1'b0;
    localparam logic OPC_CLEAR   = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] source_addr;
        logic [31:0] timestamp_seconds;
        logic        is_tcp;
        logic [15:0] target_port;
    } in_word_t;

    typedef struct packed {
        logic attack;
        logic pkt_rate_hi;
        logic conn_count_hi;
        logic conn_rate_hi;
        logic table_full;
    } out_word_t;

    // Classified job handed from the front part to the engine.
    typedef struct packed {
        logic        clear;
        logic [31:0] source;
        logic [31:0] now;
        logic        conn;
    } job_t;

    typedef struct packed {
        logic [THR_W-1:0] rate_threshold_q4;
        logic [WIN_W-1:0] window_seconds;
        logic [31:0]      conn_limit;
    } cfg_t;

    // One row of the source table memory.
    typedef struct packed {
        logic [31:0] source;
        logic [31:0] packets;
        logic [31:0] conns;
        logic [31:0] first_time;
        logic [31:0] last_time;
    } entry_t;

    // Handshake between the front queue and the engine.
    typedef struct packed {
        logic valid;
        job_t job;
    } queue_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_MUL,
        ST_CMP,
        ST_RESULT
    } eng_state_t;

endpackage

/* hdl/per_source_flood_detector.sv */
// ----------------------------------------------------------------------------
// per_source_flood_detector
// Per-source packet rate meter that raises flood flags for each packet word.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, in_data) carries one packet
// word or one table clear word. Every input word yields exactly one result
// word on the output channel (out_valid, out_stall, out_data), in order.
// Configuration is written through cfg_valid, cfg_ready, cfg_index and
// cfg_data while the block is idle; cfg_ready is always high.
// A two-word queue takes input words while the engine works, so the sender
// only stalls when that queue is full.
// In the engine a packet word passes through these steps: taking the job,
// the lookup, which reads the source table memory through its single read
// port one entry per cycle with the eviction check riding on the same pass,
// then the update, the 20x32 multiply, the compare and the result handover.
// A clear word goes from taking the job straight to the result handover.
// Reset empties the table, zeroes the sweep time and loads the default
// configuration. When the receiver stalls, the result word is held and the
// engine stops before handing over the next result.
module per_source_flood_detector (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sfd_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output sfd_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    sfd_pkg::cfg_t       cfg_reg, cfg_next;
    sfd_pkg::queue_out_t q_out;
    logic                q_pop;

    // Configuration registers are always ready; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sfd_pkg::CFG_RATE_THRESHOLD:
                    cfg_next.rate_threshold_q4 = cfg_data[sfd_pkg::THR_W-1:0];
                sfd_pkg::CFG_WINDOW:
                    cfg_next.window_seconds = cfg_data[sfd_pkg::WIN_W-1:0];
                sfd_pkg::CFG_MAX_CONN:
                    cfg_next.conn_limit = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_threshold_q4 <= 20'd1600;
            cfg_reg.window_seconds    <= 16'd60;
            cfg_reg.conn_limit        <= 32'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front part classifies and queues words.
    sfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .pop      (q_pop),
        .q_out    (q_out)
    );

    // The engine carries out one job at a time and owns the result register.
    sfd_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_in      (q_out),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* hdl/sfd_ram.sv */
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/sfd_front.sv */
// ----------------------------------------------------------------------------
// sfd_front
// Accepts input words, classifies them into jobs and queues them.
// ----------------------------------------------------------------------------
module sfd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sfd_pkg::in_word_t   in_data,
    input  logic                pop,
    output sfd_pkg::queue_out_t q_out
);

    localparam int PTR_W = (sfd_pkg::QUEUE_DEPTH > 1) ? $clog2(sfd_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(sfd_pkg::QUEUE_DEPTH + 1);

    sfd_pkg::job_t     slot_reg [sfd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    sfd_pkg::job_t     job;
    logic              push;
    logic              take;

    always_comb
    begin
        job.clear  = (in_data.opcode == sfd_pkg::OPC_CLEAR);
        job.source = in_data.source_addr;
        job.now    = in_data.timestamp_seconds;
        job.conn   = in_data.is_tcp && (in_data.target_port != 16'd0);
    end

    assign in_stall = (fill_reg == FILL_W'(sfd_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign take     = pop && (fill_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(sfd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(sfd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + FILL_W'(push) - FILL_W'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= job;
        end
    end

    assign q_out.valid = (fill_reg != '0);
    assign q_out.job   = slot_reg[rd_ptr_reg];

endmodule

/* hdl/sfd_engine.sv */
// ----------------------------------------------------------------------------
// sfd_engine
// Scans the source table, updates one entry, sweeps idle entries and
// evaluates the flood conditions for one job at a time, or clears the table.
// ----------------------------------------------------------------------------
module sfd_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfd_pkg::cfg_t        cfg,
    input  sfd_pkg::queue_out_t  q_in,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sfd_pkg::out_word_t   out_data
);

    localparam int N = sfd_pkg::TABLE_ENTRIES;
    localparam int IW = sfd_pkg::IDX_W;
    localparam int CW = sfd_pkg::CNT_W;
    localparam int EW = $bits(sfd_pkg::entry_t);

    sfd_pkg::eng_state_t state_reg, state_next;

    sfd_pkg::job_t       job_reg, job_next;
    logic                due_reg, due_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [IW-1:0]       chk_idx_reg, chk_idx_next;
    logic                hit_found_reg, hit_found_next;
    logic [IW-1:0]       hit_idx_reg, hit_idx_next;
    sfd_pkg::entry_t     hit_data_reg, hit_data_next;
    logic                free_found_reg, free_found_next;
    logic [IW-1:0]       free_idx_reg, free_idx_next;
    logic [N-1:0]        valid_reg, valid_next;
    logic [N-1:0]        evict_reg, evict_next;
    logic [31:0]         last_sweep_reg, last_sweep_next;
    sfd_pkg::entry_t     upd_reg, upd_next;
    logic [sfd_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    sfd_pkg::out_word_t  pend_reg, pend_next;
    sfd_pkg::out_word_t  res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    sfd_pkg::entry_t     ram_wdata;
    logic                ram_re;
    logic [EW-1:0]       ram_rdata;
    sfd_pkg::entry_t     rd_entry;

    logic                cur_valid;
    logic [32:0]         expire_time;
    logic [IW-1:0]       upd_idx;
    sfd_pkg::entry_t     base;
    logic [31:0]         dur;
    logic [35:0]         pk_scaled;
    logic [36:0]         cn_scaled;
    logic                hpr, hcc, hcr;
    logic                res_load;

    sfd_ram #(
        .WIDTH (EW),
        .DEPTH (N)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry    = ram_rdata;
    assign cur_valid   = valid_reg[chk_idx_reg];
    assign expire_time = {1'b0, rd_entry.last_time} + {17'd0, cfg.window_seconds};
    assign res_load    = (state_reg == sfd_pkg::ST_RESULT) && (!res_valid_reg || !out_stall);

    always_comb
    begin
        dur       = (upd_reg.last_time > upd_reg.first_time)
                    ? (upd_reg.last_time - upd_reg.first_time) : 32'd1;
        pk_scaled = {upd_reg.packets, 4'd0};
        cn_scaled = {upd_reg.conns, 5'd0};
        hpr       = ({16'd0, pk_scaled} > limit_reg);
        hcc       = (upd_reg.conns > cfg.conn_limit);
        hcr       = ({15'd0, cn_scaled} > limit_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        due_next        = due_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_data_next   = hit_data_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        evict_next      = evict_reg;
        last_sweep_next = last_sweep_reg;
        upd_next        = upd_reg;
        limit_next      = limit_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        pop             = 1'b0;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata       = upd_reg;
        upd_idx         = hit_idx_reg;
        base            = hit_data_reg;

        if (res_valid_reg && !out_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            sfd_pkg::ST_IDLE:
            begin
                if (q_in.valid)
                begin
                    pop             = 1'b1;
                    job_next        = q_in.job;
                    due_next        = ({1'b0, q_in.job.now} >
                                       ({1'b0, last_sweep_reg} + 33'(sfd_pkg::SWEEP_INTERVAL)));
                    issue_next      = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    evict_next      = '0;
                    if (q_in.job.clear)
                    begin
                        valid_next      = '0;
                        last_sweep_next = q_in.job.now;
                        pend_next       = '0;
                        state_next      = sfd_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = sfd_pkg::ST_SCAN;
                    end
                end
            end

            sfd_pkg::ST_SCAN:
            begin
                // One read is issued per cycle; the data is checked in the following cycle.
                if (issue_reg < CW'(N))
                begin
                    ram_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg[IW-1:0];
                    issue_next     = issue_reg + 1'b1;
                end
                if (chk_valid_reg)
                begin
                    if (cur_valid && !hit_found_reg && (rd_entry.source == job_reg.source))
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                        hit_data_next  = rd_entry;
                    end
                    if (!cur_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (due_reg && cur_valid && (expire_time < {1'b0, job_reg.now}))
                    begin
                        evict_next[chk_idx_reg] = 1'b1;
                    end
                end
                else if (issue_reg == CW'(N))
                begin
                    state_next = sfd_pkg::ST_UPDATE;
                end
            end

            sfd_pkg::ST_UPDATE:
            begin
                valid_next = valid_reg & ~evict_reg;
                if (due_reg)
                begin
                    last_sweep_next = job_reg.now;
                end
                if (!hit_found_reg && !free_found_reg)
                begin
                    pend_next            = '0;
                    pend_next.table_full = 1'b1;
                    state_next           = sfd_pkg::ST_RESULT;
                end
                else
                begin
                    if (!hit_found_reg)
                    begin
                        upd_idx         = free_idx_reg;
                        base.source     = job_reg.source;
                        base.packets    = '0;
                        base.conns      = '0;
                        base.first_time = job_reg.now;
                        base.last_time  = job_reg.now;
                    end
                    upd_next           = base;
                    upd_next.packets   = (base.packets == '1) ? base.packets
                                                              : base.packets + 32'd1;
                    if (job_reg.conn && (base.conns != '1))
                    begin
                        upd_next.conns = base.conns + 32'd1;
                    end
                    upd_next.last_time = job_reg.now;
                    valid_next[upd_idx] = 1'b1;
                    ram_we             = 1'b1;
                    ram_waddr          = upd_idx;
                    ram_wdata          = upd_next;
                    state_next         = sfd_pkg::ST_MUL;
                end
            end

            sfd_pkg::ST_MUL:
            begin
                limit_next = cfg.rate_threshold_q4 * dur;
                state_next = sfd_pkg::ST_CMP;
            end

            sfd_pkg::ST_CMP:
            begin
                pend_next.attack        = hpr || hcc || hcr;
                pend_next.pkt_rate_hi   = hpr;
                pend_next.conn_count_hi = hcc;
                pend_next.conn_rate_hi  = hcr;
                pend_next.table_full    = 1'b0;
                state_next              = sfd_pkg::ST_RESULT;
            end

            sfd_pkg::ST_RESULT:
            begin
                if (res_load)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = sfd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sfd_pkg::ST_IDLE;
            valid_reg      <= '0;
            last_sweep_reg <= '0;
            res_valid_reg  <= 1'b0;
            chk_valid_reg  <= 1'b0;
            issue_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            last_sweep_reg <= last_sweep_next;
            res_valid_reg  <= res_valid_next;
            chk_valid_reg  <= chk_valid_next;
            issue_reg      <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        due_reg        <= due_next;
        chk_idx_reg    <= chk_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_data_reg   <= hit_data_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        evict_reg      <= evict_next;
        upd_reg        <= upd_next;
        limit_reg      <= limit_next;
        pend_reg       <= pend_next;
        res_reg        <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

/* hdl/sfd_checker.sv */
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the flood detector, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input sfd_pkg::out_word_t out_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

    a_attack_or: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.attack == (out_data.pkt_rate_hi ||
                                           out_data.conn_count_hi ||
                                           out_data.conn_rate_hi)))
        else $error("attack is not the OR of the flood flags");

    a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.table_full |-> !out_data.attack &&
                                             !out_data.conn_count_hi)
        else $error("table full word carries flood flags");

endmodule

bind per_source_flood_detector sfd_checker u_sfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

/* bench/flood_checker.sv */
// ----------------------------------------------------------------------------
// flood_checker
// Watches the packet, result and configuration channels of the flood
// detector. It keeps its own copy of the source table and the registers,
// works out the expected flags for every accepted input word and compares
// them with the result words in order.
// ----------------------------------------------------------------------------
module flood_checker
    import sfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_word_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_word_t out_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data,
    output int        pending,
    output int        failures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    bit [THR_W-1:0] thr_q4;
    bit [WIN_W-1:0] window_s;
    bit [31:0]      max_conn;

    bit        tbl_valid [TABLE_ENTRIES];
    bit [31:0] tbl_source [TABLE_ENTRIES];
    bit [31:0] tbl_packets [TABLE_ENTRIES];
    bit [31:0] tbl_conns [TABLE_ENTRIES];
    bit [31:0] tbl_first [TABLE_ENTRIES];
    bit [31:0] tbl_last [TABLE_ENTRIES];
    bit [31:0] last_sweep;

    out_word_t flags_due [$];

    assign pending = flags_due.size();

    // Ages out idle sources, at most once every sweep interval.
    task automatic age_out(input bit [31:0] now);
        if ({32'b0, now} <= {32'b0, last_sweep} + SWEEP_INTERVAL)
            return;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i] && ({32'b0, tbl_last[i]} + window_s) < {32'b0, now})
                tbl_valid[i] = 1'b0;
        last_sweep = now;
    endtask

    task automatic meter_packet(input in_word_t w, output out_word_t r);
        int        hit;
        int        free_slot;
        bit [63:0] dur;
        bit [63:0] limit;
        hit = -1;
        free_slot = -1;
        r = '0;
        if (w.opcode == OPC_CLEAR) begin
            foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            last_sweep = w.timestamp_seconds;
            return;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                if (hit < 0 && tbl_source[i] == w.source_addr) hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit < 0) begin
            if (free_slot < 0) begin
                age_out(w.timestamp_seconds);
                r.table_full = 1'b1;
                return;
            end
            hit = free_slot;
            tbl_valid[hit] = 1'b1;
            tbl_source[hit] = w.source_addr;
            tbl_packets[hit] = '0;
            tbl_conns[hit] = '0;
            tbl_first[hit] = w.timestamp_seconds;
        end
        if (tbl_packets[hit] != COUNT_MAX) tbl_packets[hit]++;
        tbl_last[hit] = w.timestamp_seconds;
        if (w.is_tcp && w.target_port != 0 && tbl_conns[hit] != COUNT_MAX) tbl_conns[hit]++;
        age_out(w.timestamp_seconds);
        dur = (tbl_last[hit] > tbl_first[hit]) ? 64'(tbl_last[hit] - tbl_first[hit]) : 64'd1;
        limit = 64'(thr_q4) * dur;
        r.pkt_rate_hi = (64'(tbl_packets[hit]) * 16 > limit);
        r.conn_count_hi = (tbl_conns[hit] > max_conn);
        r.conn_rate_hi = (64'(tbl_conns[hit]) * 32 > limit);
        r.attack = r.pkt_rate_hi | r.conn_count_hi | r.conn_rate_hi;
    endtask

    task automatic check_flag(input string name, input bit want, input bit got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_word_t r;
        out_word_t want;
        if (!rst_n) begin
            thr_q4 = 1600;
            window_s = 60;
            max_conn = 100;
            foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            last_sweep = '0;
            flags_due.delete();
            failures = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RATE_THRESHOLD: thr_q4 = cfg_data[THR_W-1:0];
                    CFG_WINDOW:         window_s = cfg_data[WIN_W-1:0];
                    CFG_MAX_CONN:       max_conn = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                meter_packet(in_data, r);
                flags_due = {flags_due, r};
            end
            if (out_valid && !out_stall) begin
                if (flags_due.size() == 0) begin
                    $error("result word with no packet word waiting");
                    failures++;
                end else begin
                    want = flags_due.pop_front();
                    check_flag("attack", want.attack, out_data.attack);
                    check_flag("pkt_rate_hi", want.pkt_rate_hi,
                               out_data.pkt_rate_hi);
                    check_flag("conn_count_hi", want.conn_count_hi,
                               out_data.conn_count_hi);
                    check_flag("conn_rate_hi", want.conn_rate_hi,
                               out_data.conn_rate_hi);
                    check_flag("table_full", want.table_full, out_data.table_full);
                end
            end
        end
    end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the per-source flood detector.
// ----------------------------------------------------------------------------
// A directed pass covers address and time extremes, the clear operation,
// time going backwards and an eviction sweep. Then the block runs through
// several register settings, extremes included, each with random traffic
// from a small pool of sources so that counts build up and flags fire.
// One phase fills the whole table to reach the table-full case. Checking
// is done by flood_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import sfd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Both sides may idle between words. The limit allows several times
    // the slowest run.
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_WORDS = 100;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_word_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    int pending;
    int failures;
    int cycles;

    // When set, neither side idles: back-to-back words.
    bit         no_gaps;
    int         rx_hold;
    bit [31:0]  now_s;
    bit [31:0]  pool [12];

    per_source_flood_detector dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    flood_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .failures(failures)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // After taking each result word, the receiver stalls a random number of
    // cycles, unless the current phase runs without gaps.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_hold <= 0;
        end else if (rx_hold > 0) begin
            out_stall <= 1'b1;
            rx_hold <= rx_hold - 1;
        end else begin
            out_stall <= 1'b0;
            if (out_valid && !out_stall)
                rx_hold <= no_gaps ? 0 : $urandom_range(0, 11);
        end
    end

    // Holds the word until the block takes it, then idles for a random gap.
    // The valid line is only lowered when a gap follows, so back-to-back
    // words never see it dropped and raised in the same step.
    task automatic send_word(input in_word_t w);
        int gap;
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (in_stall);
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic packet(input bit [31:0] src, input bit [31:0] ts,
                          input bit tcp, input bit [15:0] port);
        in_word_t w;
        w.opcode = OPC_ANALYZE;
        w.source_addr = src;
        w.timestamp_seconds = ts;
        w.is_tcp = tcp;
        w.target_port = port;
        send_word(w);
    endtask

    task automatic clear_table(input bit [31:0] ts);
        in_word_t w;
        w = '0;
        w.opcode = OPC_CLEAR;
        w.source_addr = $urandom();
        w.timestamp_seconds = ts;
        w.is_tcp = $urandom_range(0, 1);
        w.target_port = $urandom();
        send_word(w);
    endtask

    // Waits until every result word has come back and the sender is quiet.
    task automatic drain();
        if (in_valid) in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_registers(input bit [31:0] thr, input bit [31:0] win,
                                 input bit [31:0] maxc);
        bit [31:0] vals [3];
        vals[0] = thr;
        vals[1] = win;
        vals[2] = maxc;
        drain();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly a small pool of sources at slowly moving time,
    // with sweep-sized jumps, time going backwards and the odd clear.
    task automatic random_traffic(input int count);
        int        pick;
        bit [31:0] src;
        bit [15:0] port;
        foreach (pool[i]) pool[i] = $urandom();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      now_s = now_s;
            else if (pick < 88) now_s = now_s + $urandom_range(1, 5);
            else if (pick < 95) now_s = now_s + $urandom_range(31, 120);
            else if (pick < 98) now_s = now_s - $urandom_range(1, 10);
            else                now_s = $urandom();
            src = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 11)] : $urandom();
            pick = $urandom_range(0, 9);
            port = (pick < 3) ? 16'h0 : (pick == 3) ? 16'hFFFF : 16'($urandom());
            if ($urandom_range(0, 19) == 0)
                clear_table(now_s);
            else
                packet(src, now_s, $urandom_range(0, 1), port);
        end
    endtask

    initial begin
        bit [31:0] base;
        bit [31:0] settings [8][3];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_gaps = 1'b0;
        now_s = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at the reset configuration.
        clear_table(32'd0);
        packet(32'h0000_0000, 32'd0, 1'b1, 16'h0000);
        packet(32'hFFFF_FFFF, 32'd0, 1'b1, 16'hFFFF);
        packet(32'h0000_0000, 32'd1, 1'b0, 16'h0001);
        packet(32'h0000_0000, 32'd5, 1'b1, 16'h0050);
        packet(32'h0000_0000, 32'd2, 1'b1, 16'h0050);     // time going backwards
        packet(32'hFFFF_FFFF, 32'd100, 1'b0, 16'h0000);   // sweep evicts the idle source
        packet(32'h0000_0000, 32'd100, 1'b1, 16'h8000);   // evicted source comes back new
        packet(32'hA5A5_5A5A, 32'hFFFF_FFF0, 1'b1, 16'h1234);
        packet(32'hA5A5_5A5A, 32'hFFFF_FFFF, 1'b1, 16'h4321);
        clear_table(32'hFFFF_FFFF);
        packet(32'hA5A5_5A5A, 32'd0, 1'b0, 16'h0000);     // after clear, earlier time

        // Phases across register settings, extremes first.
        settings = '{'{32'd0, 32'd0, 32'd0},
                     '{32'hFFFFF, 32'hFFFF, 32'hFFFF_FFFF},
                     '{32'd16, 32'd5, 32'd2},
                     '{32'd32, 32'd60, 32'd3},
                     '{32'd1600, 32'd60, 32'd100},
                     '{$urandom_range(0, 64), $urandom_range(0, 100), $urandom_range(0, 8)},
                     '{$urandom(), $urandom(), $urandom()},
                     '{$urandom_range(0, 400), $urandom_range(30, 200), $urandom_range(0, 20)}};
        foreach (settings[p]) begin
            set_registers(settings[p][0], settings[p][1], settings[p][2]);
            no_gaps = (p % 3 == 1);
            if (p == 6) now_s = 32'hFFFF_FF00;
            random_traffic(PHASE_WORDS);
        end

        // Fill every entry with a distinct source at one time, then overflow.
        set_registers(32'd1600, 32'd60, 32'd100);
        no_gaps = 1'b0;
        now_s = 32'd5000;
        clear_table(now_s);
        base = $urandom();
        for (int i = 0; i < TABLE_ENTRIES + 4; i++)
            packet(base ^ (i * 32'h0101_0101 + i), now_s, $urandom_range(0, 1), 16'd80);
        packet(base, now_s + 10, 1'b1, 16'd443);          // hit in a full table
        packet(~base, now_s + 200, 1'b1, 16'd22);         // full table, sweep still runs
        packet(~base, now_s + 201, 1'b1, 16'd22);         // room again after eviction

        drain();
        repeat (300) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
hdl/sfd_pkg.sv
hdl/sfd_ram.sv
hdl/sfd_front.sv
hdl/sfd_engine.sv
hdl/per_source_flood_detector.sv
hdl/sfd_checker.sv
bench/flood_checker.sv
bench/tb_top.sv
